// File: src/gppc_pkg.sv
`default_nettype none

package gppc_pkg;

    localparam int PIN_COUNT  = 106;
    localparam int PORT_COUNT = 7;

    localparam logic [6:0] PORT_BASE [0:PORT_COUNT] = '{
        7'd0, 7'd22, 7'd39, 7'd57, 7'd73, 7'd80, 7'd94, 7'd106
    };
    localparam logic [2:0] PORT_CODE [0:PORT_COUNT-1] = '{
        3'd0, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
    };

    localparam logic [3:0] OP_GET_FUNC  = 4'd0;
    localparam logic [3:0] OP_SET_FUNC  = 4'd1;
    localparam logic [3:0] OP_GET_PULL  = 4'd2;
    localparam logic [3:0] OP_SET_PULL  = 4'd3;
    localparam logic [3:0] OP_WRITE_LVL = 4'd4;
    localparam logic [3:0] OP_TOGGLE    = 4'd5;
    localparam logic [3:0] OP_READ_LVL  = 4'd6;
    localparam logic [3:0] OP_GET_DRIVE = 4'd7;
    localparam logic [3:0] OP_SET_DRIVE = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PIN    = 2'd1;
    localparam logic [1:0] ST_NO_PWM    = 2'd2;
    localparam logic [1:0] ST_BAD_DRIVE = 2'd3;

    localparam logic [3:0] FUNC_PWM        = 4'd8;
    localparam logic [2:0] FUNC_PWM_STORED = 3'd3;
    localparam logic [3:0] PULL_MAX        = 4'd2;

    typedef struct packed {
        logic [3:0] op;
        logic [6:0] pin;
        logic [3:0] val;
        logic [2:0] port;
        logic [4:0] local_pin;
        logic       pin_ok;
        logic       pwm_pin;
    } req_t;

    typedef struct packed {
        logic [2:0] port;
        logic [4:0] local_pin;
        logic       found;
    } pin_loc_t;

    function automatic pin_loc_t decode_pin(input logic [6:0] pin);
        pin_loc_t r;
        int       k;
        r = '0;
        for (k = 0; k < PORT_COUNT; k++)
        begin
            if (!r.found && pin >= PORT_BASE[k] && pin < PORT_BASE[k+1])
            begin
                r.found     = 1'b1;
                r.port      = PORT_CODE[k];
                r.local_pin = 5'(pin - PORT_BASE[k]);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/gppc_front.sv
`default_nettype none

module gppc_front #(
    parameter int PWM_PIN = 5
) (
    input  wire logic          start,
    input  wire logic [3:0]    operation,
    input  wire logic [6:0]    pin_number,
    input  wire logic [3:0]    value,
    input  wire logic          q_full,
    output logic               busy,
    output logic               push,
    output gppc_pkg::req_t     push_req
);

    gppc_pkg::pin_loc_t loc;

    always_comb
    begin
        loc                = gppc_pkg::decode_pin(pin_number);
        push_req.op        = operation;
        push_req.pin       = pin_number;
        push_req.val       = value;
        push_req.port      = loc.port;
        push_req.local_pin = loc.local_pin;
        push_req.pin_ok    = loc.found;
        push_req.pwm_pin   = (pin_number == 7'(PWM_PIN));
    end

    assign busy = q_full;
    assign push = start && !q_full;

endmodule

`default_nettype wire

// File: src/gppc_queue.sv
`default_nettype none

module gppc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire gppc_pkg::req_t push_req,
    input  wire logic           pop,
    output gppc_pkg::req_t      head,
    output logic                full,
    output logic                empty
);

    gppc_pkg::req_t slot_reg [0:1];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_req;
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// File: src/gppc_back.sv
`default_nettype none

module gppc_back #(
    parameter int MAX_DRIVE = 3
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire gppc_pkg::req_t head,
    output logic                pop,
    output logic                done,
    output logic [3:0]          read_value,
    output logic [1:0]          status,
    output logic [2:0]          port_index,
    output logic [4:0]          local_pin
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                      state_reg;
    gppc_pkg::req_t              cur_reg;
    logic                        done_reg;
    logic [3:0]                  read_value_reg;
    logic [1:0]                  status_reg;
    logic [2:0]                  port_index_reg;
    logic [4:0]                  local_pin_reg;
    logic                        rd_valid_reg;
    logic [7:0]                  rd_data_reg;
    logic [7:0]                  pin_mem [0:gppc_pkg::PIN_COUNT-1];
    logic [gppc_pkg::PIN_COUNT-1:0] valid_reg;

    logic       rd_en;
    logic       wr_en;
    logic [7:0] word;
    logic [7:0] word_next;
    logic [3:0] rd_next;
    logic [1:0] status_next;

    assign pop   = (state_reg == S_IDLE) && !q_empty;
    assign rd_en = pop && head.pin_ok;
    assign word  = rd_valid_reg ? rd_data_reg : 8'd0;
    assign wr_en = (state_reg == S_EXEC) && cur_reg.pin_ok;

    // word layout: function[7:5] pull[4:3] drive[2:1] level[0]
    always_comb
    begin
        word_next   = word;
        rd_next     = 4'd0;
        status_next = gppc_pkg::ST_OK;
        if (!cur_reg.pin_ok)
        begin
            status_next = gppc_pkg::ST_NO_PIN;
        end
        else
        begin
            case (cur_reg.op)
                gppc_pkg::OP_GET_FUNC:
                begin
                    if (word[7:5] == gppc_pkg::FUNC_PWM_STORED && cur_reg.pwm_pin)
                        rd_next = gppc_pkg::FUNC_PWM;
                    else
                        rd_next = {1'b0, word[7:5]};
                end
                gppc_pkg::OP_SET_FUNC:
                begin
                    if (cur_reg.val == gppc_pkg::FUNC_PWM)
                    begin
                        if (cur_reg.pwm_pin)
                            word_next[7:5] = gppc_pkg::FUNC_PWM_STORED;
                        else
                            status_next = gppc_pkg::ST_NO_PWM;
                    end
                    else if (cur_reg.val < gppc_pkg::FUNC_PWM)
                    begin
                        word_next[7:5] = cur_reg.val[2:0];
                    end
                end
                gppc_pkg::OP_GET_PULL:
                    rd_next = {2'b00, word[4:3]};
                gppc_pkg::OP_SET_PULL:
                begin
                    if (cur_reg.val <= gppc_pkg::PULL_MAX)
                        word_next[4:3] = cur_reg.val[1:0];
                end
                gppc_pkg::OP_WRITE_LVL:
                    word_next[0] = (cur_reg.val != 4'd0);
                gppc_pkg::OP_TOGGLE:
                    word_next[0] = ~word[0];
                gppc_pkg::OP_READ_LVL:
                    rd_next = {3'b000, word[0]};
                gppc_pkg::OP_GET_DRIVE:
                    rd_next = {2'b00, word[2:1]};
                gppc_pkg::OP_SET_DRIVE:
                begin
                    if (cur_reg.val <= 4'(MAX_DRIVE))
                        word_next[2:1] = cur_reg.val[1:0];
                    else
                        status_next = gppc_pkg::ST_BAD_DRIVE;
                end
                default:
                    word_next = word;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            done_reg       <= 1'b0;
            read_value_reg <= 4'd0;
            status_reg     <= gppc_pkg::ST_OK;
            port_index_reg <= 3'd0;
            local_pin_reg  <= 5'd0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg      <= head;
                        rd_valid_reg <= head.pin_ok && valid_reg[head.pin];
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    done_reg       <= 1'b1;
                    read_value_reg <= rd_next;
                    status_reg     <= status_next;
                    port_index_reg <= cur_reg.port;
                    local_pin_reg  <= cur_reg.local_pin;
                    state_reg      <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[cur_reg.pin] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pin_mem[cur_reg.pin] <= word_next;
        if (rd_en)
            rd_data_reg <= pin_mem[head.pin];
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign port_index = port_index_reg;
    assign local_pin  = local_pin_reg;

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_EXEC) && (cur_reg.pin < 7'(gppc_pkg::PIN_COUNT)))
        else $error("pin store written outside execute or out of range");

    a_no_pin_fields: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == gppc_pkg::ST_NO_PIN |->
            read_value_reg == 4'd0 && port_index_reg == 3'd0 && local_pin_reg == 5'd0)
        else $error("missing pin result carries nonzero fields");

    a_exec_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_EXEC)
        else $error("request popped without execute");

endmodule

`default_nettype wire

// File: src/gpio_pin_port_controller_top.sv
`default_nettype none

// gpio pin controller: one request is one access to one pin, addressed by
// a global pin number over ports a, c, d, e, f, g, l (port b has no pins)
// request channel: start, operation, pin_number, value; taken at a clock
// edge where start is high and busy is low
// result channel: done is high for exactly one cycle with read_value,
// status, port_index and local_pin; the receiver cannot hold it off
// with the queue empty and the back end idle, a request is written into the
// queue, then popped into the back end's execute state, which registers done
// with the result; no new request is popped until then, since the per-pin
// store is read on the pop and written back in execute through its single port
// a 2-entry queue sits between the decoder and the pin store, so up to
// two decoded requests may wait; busy is high while the queue is full
// reset: all pin function, pull, drive and level settings read as zero,
// the queue is emptied and no result is pending; no clearing pass
module gpio_pin_port_controller_top #(
    parameter int PWM_PIN   = 5,
    parameter int MAX_DRIVE = 3
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [3:0] operation,
    input  wire logic [6:0] pin_number,
    input  wire logic [3:0] value,
    output logic            done,
    output logic [3:0]      read_value,
    output logic [1:0]      status,
    output logic [2:0]      port_index,
    output logic [4:0]      local_pin
);

    gppc_pkg::req_t push_req;
    gppc_pkg::req_t head;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    gppc_front #(
        .PWM_PIN (PWM_PIN)
    ) u_front (
        .start      (start),
        .operation  (operation),
        .pin_number (pin_number),
        .value      (value),
        .q_full     (q_full),
        .busy       (busy),
        .push       (push),
        .push_req   (push_req)
    );

    gppc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    gppc_back #(
        .MAX_DRIVE (MAX_DRIVE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .read_value (read_value),
        .status     (status),
        .port_index (port_index),
        .local_pin  (local_pin)
    );

endmodule

`default_nettype wire
